// ----- design/lcdns_pkg.sv -----
// Shared types, codes and tables for the character LCD nibble sequencer.
`default_nettype none

package lcdns_pkg;

	localparam logic [1:0] ACT_INIT = 2'd0;
	localparam logic [1:0] ACT_CMD  = 2'd1;
	localparam logic [1:0] ACT_DATA = 2'd2;
	localparam logic [1:0] ACT_HEX  = 2'd3;

	localparam logic [1:0] REG_PULSE_WIDTH = 2'd0;
	localparam logic [1:0] REG_WAKE_SETUP  = 2'd1;
	localparam logic [1:0] REG_SHORT_WAIT  = 2'd2;
	localparam logic [1:0] REG_LONG_WAIT   = 2'd3;

	localparam logic [7:0] RST_PULSE_WIDTH = 8'd1;
	localparam logic [7:0] RST_WAKE_SETUP  = 8'd10;
	localparam logic [7:0] RST_SHORT_WAIT  = 8'd1;
	localparam logic [7:0] RST_LONG_WAIT   = 8'd3;

	localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
	localparam logic [3:0] BUS4_NIBBLE    = 4'h2;
	localparam logic [3:0] WAKE_STROBES   = 4'd4;
	localparam logic [7:0] SLOW_CMD_LIMIT = 8'd4;
	localparam logic [7:0] ASCII_DIGIT    = 8'd48;
	localparam logic [7:0] ASCII_ALPHA    = 8'd55;
	localparam logic [3:0] DEC_DIGITS     = 4'd10;

	localparam logic [3:0] LAST_IDX_INIT = 4'd11;
	localparam logic [3:0] LAST_IDX_BYTE = 4'd1;
	localparam logic [3:0] LAST_IDX_HEX  = 4'd7;

	typedef enum logic [1:0] {
		KIND_INIT,
		KIND_CMD,
		KIND_DATA,
		KIND_HEX
	} kind_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] value;
	} req_t;

	typedef struct packed {
		logic [3:0] data_nibble;
		logic       register_select;
		logic [7:0] setup_ms;
		logic [7:0] pulse_ms;
		logic [7:0] wait_after_ms;
		logic       last;
	} strobe_t;

	typedef struct packed {
		logic [7:0] pulse_width_ms;
		logic [7:0] wake_setup_ms;
		logic [7:0] short_wait_ms;
		logic [7:0] long_wait_ms;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic [3:0]  last_idx;
	} entry_t;

	function automatic logic [7:0] init_cmd(input logic [1:0] sel);
		logic [7:0] c;
		unique case (sel)
			2'd0: c = 8'h28;
			2'd1: c = 8'h10;
			2'd2: c = 8'h0F;
			default: c = 8'h06;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] hex_ascii(input logic [3:0] d);
		logic [7:0] r;
		if (d < DEC_DIGITS)
			r = {4'h0, d} + ASCII_DIGIT;
		else
			r = {4'h0, d} + ASCII_ALPHA;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/lcdns_front.sv -----
// Request intake: classifies each request and queues it for the strobe sequencer.
`default_nettype none

module lcdns_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire lcdns_pkg::req_t in_req,
	input  wire logic            pop,
	output logic                 head_valid,
	output lcdns_pkg::entry_t    head
);

	lcdns_pkg::entry_t entry_d;
	lcdns_pkg::entry_t entries_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;

	always_comb begin
		entry_d.value    = in_req.value;
		entry_d.kind     = lcdns_pkg::KIND_HEX;
		entry_d.last_idx = lcdns_pkg::LAST_IDX_HEX;
		unique case (in_req.action)
			lcdns_pkg::ACT_INIT: begin
				entry_d.kind     = lcdns_pkg::KIND_INIT;
				entry_d.last_idx = lcdns_pkg::LAST_IDX_INIT;
			end
			lcdns_pkg::ACT_CMD: begin
				entry_d.kind     = lcdns_pkg::KIND_CMD;
				entry_d.value    = {8'h00, in_req.value[7:0]};
				entry_d.last_idx = lcdns_pkg::LAST_IDX_BYTE;
			end
			lcdns_pkg::ACT_DATA: begin
				entry_d.kind     = lcdns_pkg::KIND_DATA;
				entry_d.value    = {8'h00, in_req.value[7:0]};
				entry_d.last_idx = lcdns_pkg::LAST_IDX_BYTE;
			end
			default: begin
				entry_d.kind     = lcdns_pkg::KIND_HEX;
				entry_d.last_idx = lcdns_pkg::LAST_IDX_HEX;
			end
		endcase
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != 2'd0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= entry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- design/lcdns_back.sv -----
// Strobe sequencer: steps through a queued request and emits one strobe per cycle while the output is not stalled.
`default_nettype none

module lcdns_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lcdns_pkg::cfg_t   cfg,
	input  wire logic              head_valid,
	input  wire lcdns_pkg::entry_t head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output lcdns_pkg::strobe_t     out_res
);

	logic [3:0]         idx_q;
	logic               out_valid_q;
	lcdns_pkg::strobe_t out_q;
	lcdns_pkg::strobe_t strobe;
	logic               advance;
	logic [3:0]         rel_idx;
	logic [7:0]         cmd_byte;
	logic [3:0]         digit;
	logic [7:0]         ascii;

	always_comb begin
		rel_idx  = idx_q - lcdns_pkg::WAKE_STROBES;
		cmd_byte = head.value[7:0];
		digit    = head.value[15:12];
		case (idx_q[2:1])
			2'd0:    digit = head.value[15:12];
			2'd1:    digit = head.value[11:8];
			2'd2:    digit = head.value[7:4];
			default: digit = head.value[3:0];
		endcase
		ascii = lcdns_pkg::hex_ascii(digit);

		strobe.pulse_ms        = cfg.pulse_width_ms;
		strobe.last            = (idx_q == head.last_idx);
		strobe.register_select = 1'b0;
		strobe.setup_ms        = 8'd0;
		strobe.wait_after_ms   = 8'd0;
		strobe.data_nibble     = 4'h0;

		unique case (head.kind)
			lcdns_pkg::KIND_INIT: begin
				if (idx_q < lcdns_pkg::WAKE_STROBES) begin
					if (idx_q == lcdns_pkg::WAKE_STROBES - 4'd1) begin
						strobe.data_nibble = lcdns_pkg::BUS4_NIBBLE;
						strobe.setup_ms    = cfg.wake_setup_ms;
					end else begin
						strobe.data_nibble   = lcdns_pkg::WAKE_NIBBLE;
						strobe.wait_after_ms = cfg.short_wait_ms;
						if (idx_q == 4'd0)
							strobe.setup_ms = cfg.wake_setup_ms;
					end
				end else begin
					cmd_byte = lcdns_pkg::init_cmd(rel_idx[2:1]);
					strobe.data_nibble = idx_q[0] ? cmd_byte[3:0] : cmd_byte[7:4];
					if (idx_q[0])
						strobe.wait_after_ms = (cmd_byte < lcdns_pkg::SLOW_CMD_LIMIT) ?
							cfg.long_wait_ms : cfg.short_wait_ms;
				end
			end
			lcdns_pkg::KIND_CMD: begin
				strobe.data_nibble = idx_q[0] ? cmd_byte[3:0] : cmd_byte[7:4];
				if (idx_q[0])
					strobe.wait_after_ms = (cmd_byte < lcdns_pkg::SLOW_CMD_LIMIT) ?
						cfg.long_wait_ms : cfg.short_wait_ms;
			end
			lcdns_pkg::KIND_DATA: begin
				strobe.register_select = 1'b1;
				strobe.data_nibble     = idx_q[0] ? cmd_byte[3:0] : cmd_byte[7:4];
			end
			default: begin
				strobe.register_select = 1'b1;
				strobe.data_nibble     = idx_q[0] ? ascii[3:0] : ascii[7:4];
			end
		endcase
	end

	assign advance   = head_valid && (!out_valid_q || out_ready);
	assign pop       = advance && strobe.last;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= strobe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= strobe.last ? 4'd0 : idx_q + 4'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= head.last_idx))
		else $error("strobe index ran past end of request");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (idx_q == 4'd0))
		else $error("strobe index not cleared between requests");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && strobe.last) |=> (idx_q == 4'd0 && out_valid_q && out_q.last))
		else $error("final strobe did not close the request");

endmodule

`default_nettype wire

// ----- design/char_lcd_nibble_sequencer.sv -----
// Top level of the 4-bit character LCD nibble sequencer.
`default_nettype none

// Each request (init, command byte, data byte, or hex of a 16-bit value) is
// expanded into enable strobes for a 4-bit character LCD bus, one strobe per
// result, carrying nibble, register select and the setup, pulse and after
// waits in milliseconds. The strobe sequencer emits one strobe per clock
// while the output is not stalled; a request has 2 strobes for command and
// data, 8 for hex, 12 for init. A two-entry request queue in front lets new
// requests be taken while the sequencer works and the output register holds a
// strobe that has not been taken yet; an accepted request is first written
// into the queue and its first strobe is then registered in the output
// register. Timing registers are written through the cfg channel, which is
// always ready, and must only change while no request is in flight.

module char_lcd_nibble_sequencer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire lcdns_pkg::req_t    in_req,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output lcdns_pkg::strobe_t      out_res,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data
);

	lcdns_pkg::cfg_t   cfg_q;
	lcdns_pkg::entry_t head;
	logic              head_valid;
	logic              pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_width_ms <= lcdns_pkg::RST_PULSE_WIDTH;
			cfg_q.wake_setup_ms  <= lcdns_pkg::RST_WAKE_SETUP;
			cfg_q.short_wait_ms  <= lcdns_pkg::RST_SHORT_WAIT;
			cfg_q.long_wait_ms   <= lcdns_pkg::RST_LONG_WAIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lcdns_pkg::REG_PULSE_WIDTH: cfg_q.pulse_width_ms <= cfg_data;
				lcdns_pkg::REG_WAKE_SETUP:  cfg_q.wake_setup_ms  <= cfg_data;
				lcdns_pkg::REG_SHORT_WAIT:  cfg_q.short_wait_ms  <= cfg_data;
				default:                    cfg_q.long_wait_ms   <= cfg_data;
			endcase
		end
	end

	lcdns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_req     (in_req),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lcdns_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (out_res)
	);

endmodule

`default_nettype wire

// ----- test/char_lcd_nibble_sequencer_test.sv -----
`timescale 1ns / 100ps
// Testbench for the character LCD nibble sequencer: directed and random requests checked against predicted strobes.

module char_lcd_nibble_sequencer_test;

	import lcdns_pkg::*;

	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          PHASES      = 6;
	localparam int          PHASE_REQS  = 54;
	localparam logic [31:0] INIT_CMDS   = 32'h28100F06;
	localparam logic        RS_CMD      = 1'b0;
	localparam logic        RS_DATA     = 1'b1;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	req_t    in_req = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	strobe_t out_res;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	cfg_t    timing;
	req_t    requests_queued[$];
	strobe_t strobes_due[$];
	int      mismatches = 0;
	int      cycle_count = 0;
	int      send_gap, send_calm, hold_left, hold_calm;

	char_lcd_nibble_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic add_strobe(logic [3:0] nib, logic rs, logic [7:0] setup,
			logic [7:0] after, logic fin);
		strobe_t s;
		s.data_nibble     = nib;
		s.register_select = rs;
		s.setup_ms        = setup;
		s.pulse_ms        = timing.pulse_width_ms;
		s.wait_after_ms   = after;
		s.last            = fin;
		strobes_due.push_back(s);
	endtask

	task automatic add_byte(logic [7:0] b, logic rs, logic fin);
		logic [7:0] after;
		if (rs == RS_DATA)
			after = 8'd0;
		else if (b < SLOW_CMD_LIMIT)
			after = timing.long_wait_ms;
		else
			after = timing.short_wait_ms;
		add_strobe(b[7:4], rs, 8'd0, 8'd0, 1'b0);
		add_strobe(b[3:0], rs, 8'd0, after, fin);
	endtask

	task automatic expand_request(req_t r);
		int i;
		logic [3:0] digit;
		logic [7:0] ch;
		case (r.action)
			ACT_INIT: begin
				add_strobe(WAKE_NIBBLE, RS_CMD, timing.wake_setup_ms, timing.short_wait_ms, 1'b0);
				add_strobe(WAKE_NIBBLE, RS_CMD, 8'd0, timing.short_wait_ms, 1'b0);
				add_strobe(WAKE_NIBBLE, RS_CMD, 8'd0, timing.short_wait_ms, 1'b0);
				add_strobe(BUS4_NIBBLE, RS_CMD, timing.wake_setup_ms, 8'd0, 1'b0);
				for (i = 0; i < 4; i++)
					add_byte(INIT_CMDS[31 - 8 * i -: 8], RS_CMD, i == 3);
			end
			ACT_CMD: add_byte(r.value[7:0], RS_CMD, 1'b1);
			ACT_DATA: add_byte(r.value[7:0], RS_DATA, 1'b1);
			default: begin
				for (i = 3; i >= 0; i--) begin
					digit = r.value[4 * i +: 4];
					ch = (digit < 4'd10) ? 8'd48 + digit : 8'd55 + digit;
					add_byte(ch, RS_DATA, i == 0);
				end
			end
		endcase
	endtask

	task automatic queue_req(logic [1:0] act, logic [15:0] v);
		req_t r;
		r.action = act;
		r.value  = v;
		requests_queued.push_back(r);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			REG_PULSE_WIDTH: timing.pulse_width_ms = d;
			REG_WAKE_SETUP:  timing.wake_setup_ms  = d;
			REG_SHORT_WAIT:  timing.short_wait_ms  = d;
			default:         timing.long_wait_ms   = d;
		endcase
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (requests_queued.size() != 0 || in_valid || strobes_due.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			in_req    <= '0;
			send_gap  <= 0;
			send_calm <= 0;
		end else begin
			if (in_valid && in_ready)
				expand_request(in_req);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (requests_queued.size() != 0) begin
					in_valid <= 1'b1;
					in_req   <= requests_queued.pop_front();
					send_gap <= (send_calm != 0) ? 0 : pick_pause();
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (send_calm != 0)
				send_calm <= send_calm - 1;
			else if ($urandom_range(0, 99) < 2)
				send_calm <= $urandom_range(20, 80);
		end
	end

	// strobe monitor
	always @(posedge clk or negedge arst_n) begin
		strobe_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_calm <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (strobes_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected strobe %h", out_res);
					mismatches++;
				end else begin
					want = strobes_due.pop_front();
					if (out_res.data_nibble !== want.data_nibble ||
							out_res.register_select !== want.register_select ||
							out_res.setup_ms !== want.setup_ms ||
							out_res.pulse_ms !== want.pulse_ms ||
							out_res.wait_after_ms !== want.wait_after_ms ||
							out_res.last !== want.last) begin
						if (mismatches < 10)
							$display("strobe mismatch: want nib %h rs %b setup %0d pulse %0d after %0d last %b, got nib %h rs %b setup %0d pulse %0d after %0d last %b",
								want.data_nibble, want.register_select, want.setup_ms,
								want.pulse_ms, want.wait_after_ms, want.last,
								out_res.data_nibble, out_res.register_select,
								out_res.setup_ms, out_res.pulse_ms,
								out_res.wait_after_ms, out_res.last);
						mismatches++;
					end
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_calm == 0 && $urandom_range(0, 99) < 20) begin
				out_ready <= 1'b0;
				hold_left <= pick_pause();
			end else begin
				out_ready <= 1'b1;
			end
			if (hold_calm != 0)
				hold_calm <= hold_calm - 1;
			else if ($urandom_range(0, 99) < 2)
				hold_calm <= $urandom_range(20, 80);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int p, n, r;
		logic [15:0] v;
		logic [31:0] setting;
		timing.pulse_width_ms = RST_PULSE_WIDTH;
		timing.wake_setup_ms  = RST_WAKE_SETUP;
		timing.short_wait_ms  = RST_SHORT_WAIT;
		timing.long_wait_ms   = RST_LONG_WAIT;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed pass at reset timing
		queue_req(ACT_INIT, 16'h0000);
		queue_req(ACT_CMD, 16'h0000);
		queue_req(ACT_CMD, 16'h0001);
		queue_req(ACT_CMD, 16'h0003);
		queue_req(ACT_CMD, 16'h0004);
		queue_req(ACT_CMD, 16'h00FF);
		queue_req(ACT_CMD, 16'h0080);
		queue_req(ACT_CMD, 16'hAB02);
		queue_req(ACT_DATA, 16'h0000);
		queue_req(ACT_DATA, 16'h00FF);
		queue_req(ACT_DATA, 16'h5541);
		queue_req(ACT_DATA, 16'hFF7F);
		queue_req(ACT_HEX, 16'h0000);
		queue_req(ACT_HEX, 16'hFFFF);
		queue_req(ACT_HEX, 16'h9A09);
		queue_req(ACT_HEX, 16'h1234);
		queue_req(ACT_HEX, 16'hA5F0);
		queue_req(ACT_INIT, 16'hFFFF);
		drain();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: setting = 32'h00000000;
				1: setting = 32'hFFFFFFFF;
				2: setting = 32'hFF00FF00;
				3: setting = 32'h00FF00FF;
				default: setting = $urandom;
			endcase
			write_reg(REG_PULSE_WIDTH, setting[31:24]);
			write_reg(REG_WAKE_SETUP, setting[23:16]);
			write_reg(REG_SHORT_WAIT, setting[15:8]);
			write_reg(REG_LONG_WAIT, setting[7:0]);
			for (n = 0; n < PHASE_REQS; n++) begin
				r = $urandom_range(0, 99);
				v = 16'($urandom_range(0, 65535));
				if (r < 8) begin
					queue_req(ACT_INIT, v);
				end else if (r < 45) begin
					// bias toward the slow clear/home commands
					if ($urandom_range(0, 3) == 0)
						v[7:0] = 8'($urandom_range(0, 4));
					queue_req(ACT_CMD, v);
				end else if (r < 72) begin
					queue_req(ACT_DATA, v);
				end else begin
					queue_req(ACT_HEX, v);
				end
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && strobes_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
